>>> rtl/rvpid_pkg.sv
`timescale 1ns / 1ps
package rvpid_pkg;

  localparam int CNT_W      = 12;
  localparam int DELTA_W    = 12;
  localparam int VEL_W      = 24;
  localparam int SPD_W      = 24;
  localparam int ACCEL_W    = 20;
  localparam int DIST_W     = 32;
  localparam int WIN_W      = 31;
  localparam int GAIN_W     = 24;
  localparam int ERR_W      = 26;
  localparam int EWS_W      = 28;
  localparam int AVG_W      = 32;
  localparam int ACC_W      = 40;
  localparam int ACC_SUM_W  = ACC_W + 2;
  localparam int MUL_A_W    = GAIN_W + 1;
  localparam int MUL_B_W    = 28;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int SUM_W      = MUL_P_W + 3;
  localparam int PID_SHIFT  = 16;
  localparam int DUTY_W     = 12;
  localparam int MEAN_W     = 16;
  localparam int MEAN_IN_W  = AVG_W - 8;
  localparam int STAGE_W    = 2;
  localparam int ZT_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int ERROR_TAPS            = 4;
  localparam int DEFAULT_AVERAGE_DEPTH = 100;

  localparam int VEL_PER_COUNT = 4191;
  localparam int PID_LIMIT     = 8995;
  localparam int ZERO_TICKS_MAX = 3;

  localparam logic signed [MUL_P_W-1:0] I_LIMIT = MUL_P_W'(64'sd5 <<< 24);
  localparam logic signed [ACC_W-1:0]   ACC_LIMIT = ACC_W'(PID_LIMIT * 256);
  localparam logic signed [ACC_W-1:0]   ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]   ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [GAIN_W-1:0]  GAIN_P_RST = '0;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST = GAIN_W'(1);
  localparam logic [GAIN_W-1:0]  GAIN_D_RST = '0;
  localparam logic [ACCEL_W-1:0] ACCEL_RST  = ACCEL_W'(845);

  localparam logic [STAGE_W-1:0] STAGE_RUN  = 2'd0;
  localparam logic [STAGE_W-1:0] STAGE_ZERO = 2'd1;
  localparam logic [STAGE_W-1:0] STAGE_SLOW = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P   = 3'd0,
    REG_GAIN_I   = 3'd1,
    REG_GAIN_D   = 3'd2,
    REG_ACCEL    = 3'd3,
    REG_TARGET   = 3'd4,
    REG_WINDOW   = 3'd5,
    REG_CRUISE   = 3'd6,
    REG_DECEL    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] encoder_count;
    logic             drive_enable;
  } in_beat_t;

  typedef struct packed {
    logic [DUTY_W-1:0]        duty;
    logic                     forward;
    logic signed [MEAN_W-1:0] speed_now;
    logic signed [MEAN_W-1:0] speed_mean;
    logic signed [DIST_W-1:0] distance_left;
    logic [STAGE_W-1:0]       stop_stage;
    logic                     motion_done;
  } out_beat_t;

endpackage

>>> rtl/rvpid_ram.sv
`timescale 1ns / 1ps
module rvpid_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

>>> rtl/rvpid_mul.sv
`timescale 1ns / 1ps
module rvpid_mul import rvpid_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

>>> rtl/rvpid_div.sv
`timescale 1ns / 1ps
module rvpid_div import rvpid_pkg::*; #(
  parameter int DEPTH = DEFAULT_AVERAGE_DEPTH
) (
  input  logic signed [MEAN_IN_W-1:0] y,
  input  logic signed [MUL_P_W-1:0]   p,
  output logic signed [MUL_A_W-1:0]   u,
  output logic signed [MUL_B_W-1:0]   m,
  output logic signed [MEAN_W-1:0]    q
);

  // largest integer speed magnitude; |y| never exceeds DEPTH times this
  localparam longint QB    = longint'(VEL_PER_COUNT) * 1024 / 256;
  localparam longint U_MAX = 2 * longint'(DEPTH) * QB;
  localparam int     SH    = $clog2(U_MAX * longint'(DEPTH));
  localparam longint RECIP = ((longint'(1) <<< SH) + longint'(DEPTH) - 1) / longint'(DEPTH);

  // bias y by DEPTH*QB so the reciprocal multiply sees a nonnegative operand,
  // then remove QB from the quotient; gives floor(y / DEPTH)
  assign u = {{(MUL_A_W-MEAN_IN_W){y[MEAN_IN_W-1]}}, y} + MUL_A_W'(longint'(DEPTH) * QB);
  assign m = MUL_B_W'(RECIP);
  assign q = MEAN_W'((p >>> SH) - MUL_P_W'(QB));

endmodule

>>> rtl/ramped_velocity_pid_motor_control.sv
`timescale 1ns / 1ps
// Velocity loop for one motor with a trapezoidal ramp and a distance stop.
// One input beat is one control tick: encoder count since the last tick and
// the drive enable. Each tick gives exactly one result beat: duty, direction,
// speeds, distance left, stop stage and done flag.
// Channels use valid/stall; a beat moves when valid is high and stall low.
// in_stall is high while a tick is being worked on. After the input beat is
// taken come four front-end steps, then the shared multiplier runs the P, D
// and I terms and the mean (reciprocal multiply), then the accumulator
// update and the output step. A new beat is taken only after the output
// step has registered the result, so ticks never overlap.
// The result sits in an output register; a new tick is taken while it waits,
// but the next result is held back (input stalled) until it has been taken.
// Configuration must be written through cfg_we/cfg_index/cfg_data while idle;
// the block itself does not enforce it. Cruise writes only load the commanded velocity.
// Synchronous reset clears all loop state, restores register defaults and
// empties the speed average window (no clearing pass is needed).
module ramped_velocity_pid_motor_control import rvpid_pkg::*; #(
  parameter int AVERAGE_DEPTH = DEFAULT_AVERAGE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(AVERAGE_DEPTH);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_FRONT = 11'b00000000010,
    S_CMD  = 11'b00000000100,
    S_RAMP = 11'b00000001000,
    S_ERR  = 11'b00000010000,
    S_MULP = 11'b00000100000,
    S_MULD = 11'b00001000000,
    S_MULI = 11'b00010000000,
    S_ACC1 = 11'b00100000000,
    S_ACC2 = 11'b01000000000,
    S_WAIT = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0]         gain_p_r, gain_i_r, gain_d_r;
  logic [ACCEL_W-1:0]        accel_r;
  logic signed [DIST_W-1:0]  target_r;
  logic [WIN_W-1:0]          window_r;
  logic signed [SPD_W-1:0]   decel_r;

  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      en_r, en_nxt;
  logic signed [DELTA_W-1:0] delta_r, delta_nxt;
  logic signed [VEL_W-1:0]   vel_r, vel_nxt;
  logic [DIST_W-1:0]         trav_r, trav_nxt;
  logic signed [DIST_W-1:0]  rem_r, rem_nxt;
  logic signed [SPD_W-1:0]   cmd_r, cmd_nxt;
  logic signed [SPD_W-1:0]   ramp_r, ramp_nxt;
  logic [STAGE_W-1:0]        stage_r, stage_nxt;
  logic [ZT_W-1:0]           zt_r, zt_nxt;
  logic                      done_r, done_nxt;
  logic [AW-1:0]             pos_r, pos_nxt;
  logic                      full_r, full_nxt;
  logic signed [AVG_W-1:0]   avg_r, avg_nxt;
  logic signed [ERR_W-1:0]   eh_r [ERROR_TAPS];
  logic signed [ERR_W-1:0]   eh_nxt [ERROR_TAPS];
  logic signed [EWS_W-1:0]   ews_r, ews_nxt;
  logic signed [MUL_B_W-1:0] dsum_r, dsum_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [MEAN_W-1:0]  mean_r, mean_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_beat_t                 out_r, out_nxt;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [MUL_A_W-1:0] div_u;
  logic signed [MUL_B_W-1:0] div_m;
  logic signed [MEAN_W-1:0]  div_q;
  logic                      ram_we;
  logic [VEL_W-1:0]          ram_q;

  logic                      accept;
  logic signed [DELTA_W:0]   fwd_c;
  logic signed [DELTA_W-1:0] delta_c;
  logic [DIST_W-1:0]         rem_c, rem_mag;
  logic signed [SPD_W+1:0]   up_c, dn_c;
  logic signed [ERR_W-1:0]   e0_c;
  logic signed [VEL_W-1:0]   old_c;
  logic signed [MUL_P_W-1:0] it_c;
  logic signed [ACC_SUM_W-1:0] accs_c;
  logic signed [ACC_W-1:0]   accsat_c, mag_c;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  rvpid_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  rvpid_div #(.DEPTH(AVERAGE_DEPTH)) u_div (
    .y (avg_r[AVG_W-1:8]),
    .p (mul_p),
    .u (div_u),
    .m (div_m),
    .q (div_q)
  );

  rvpid_ram #(.WIDTH(VEL_W), .DEPTH(AVERAGE_DEPTH)) u_win (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (pos_r),
    .wdata   (vel_r),
    .raddr   (pos_r),
    .rdata_r (ram_q)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MULP: begin
        mul_a = {1'b0, gain_p_r};
        mul_b = MUL_B_W'(eh_r[0]);
      end
      S_MULD: begin
        mul_a = {1'b0, gain_d_r};
        mul_b = dsum_r;
      end
      S_MULI: begin
        mul_a = {1'b0, gain_i_r};
        mul_b = ews_r;
      end
      S_ACC1: begin
        mul_a = div_u;
        mul_b = div_m;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    en_nxt        = en_r;
    delta_nxt     = delta_r;
    vel_nxt       = vel_r;
    trav_nxt      = trav_r;
    rem_nxt       = rem_r;
    cmd_nxt       = cmd_r;
    ramp_nxt      = ramp_r;
    stage_nxt     = stage_r;
    zt_nxt        = zt_r;
    done_nxt      = done_r;
    pos_nxt       = pos_r;
    full_nxt      = full_r;
    avg_nxt       = avg_r;
    eh_nxt        = eh_r;
    ews_nxt       = ews_r;
    dsum_nxt      = dsum_r;
    sum_nxt       = sum_r;
    acc_nxt       = acc_r;
    mean_nxt      = mean_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;

    fwd_c   = (DELTA_W+1)'(2049) - $signed({1'b0, cnt_r});
    if (cnt_r > CNT_W'(1024)) begin
      if (fwd_c < -(DELTA_W+1)'(1024)) begin
        delta_c = -DELTA_W'(1024);
      end else begin
        delta_c = fwd_c[DELTA_W-1:0];
      end
    end else begin
      delta_c = -$signed(cnt_r);
    end

    rem_c   = target_r - trav_r;
    rem_mag = rem_c[DIST_W-1] ? (DIST_W'(0) - rem_c) : rem_c;
    up_c    = (SPD_W+2)'(ramp_r) + $signed({6'b0, accel_r});
    dn_c    = (SPD_W+2)'(ramp_r) - $signed({6'b0, accel_r});
    e0_c    = ERR_W'(ramp_r) - ERR_W'(vel_r);
    old_c   = full_r ? $signed(ram_q) : '0;
    it_c    = (mul_p > I_LIMIT) ? I_LIMIT : ((mul_p < -I_LIMIT) ? -I_LIMIT : mul_p);
    accs_c  = ACC_SUM_W'(acc_r) + ACC_SUM_W'($signed(sum_r[SUM_W-1:PID_SHIFT]));
    if (accs_c > ACC_SUM_W'(ACC_MAX)) begin
      accsat_c = ACC_MAX;
    end else if (accs_c < ACC_SUM_W'(ACC_MIN)) begin
      accsat_c = ACC_MIN;
    end else begin
      accsat_c = accs_c[ACC_W-1:0];
    end
    mag_c   = acc_r[ACC_W-1] ? -acc_r : acc_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt   = in_data.encoder_count;
          en_nxt    = in_data.drive_enable;
          state_nxt = S_FRONT;
        end
      end
      S_FRONT: begin
        delta_nxt = delta_c;
        vel_nxt   = VEL_W'(delta_c * $signed(15'(VEL_PER_COUNT)));
        trav_nxt  = trav_r + DIST_W'(delta_c);
        state_nxt = S_CMD;
      end
      S_CMD: begin
        rem_nxt = rem_c;
        if (stage_r == STAGE_RUN && rem_mag <= {1'b0, window_r}) begin
          cmd_nxt   = decel_r;
          stage_nxt = (decel_r == '0) ? STAGE_ZERO : STAGE_SLOW;
        end
        if (stage_nxt == STAGE_ZERO && delta_r == '0) begin
          if (zt_r == ZT_W'(ZERO_TICKS_MAX)) begin
            done_nxt = 1'b1;
            zt_nxt   = '0;
          end else begin
            zt_nxt = zt_r + 1'b1;
          end
        end else begin
          zt_nxt   = '0;
          done_nxt = 1'b0;
        end
        state_nxt = S_RAMP;
      end
      S_RAMP: begin
        if (cmd_r > ramp_r) begin
          ramp_nxt = ((SPD_W+2)'(cmd_r) < up_c) ? cmd_r : up_c[SPD_W-1:0];
        end else if (cmd_r < ramp_r) begin
          ramp_nxt = ((SPD_W+2)'(cmd_r) > dn_c) ? cmd_r : dn_c[SPD_W-1:0];
        end
        state_nxt = S_ERR;
      end
      S_ERR: begin
        avg_nxt = avg_r + AVG_W'(vel_r) - AVG_W'(old_c);
        ram_we  = 1'b1;
        if (pos_r == AW'(AVERAGE_DEPTH - 1)) begin
          pos_nxt  = '0;
          full_nxt = 1'b1;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
        for (int i = ERROR_TAPS - 1; i > 0; i--) begin
          eh_nxt[i] = eh_r[i-1];
        end
        eh_nxt[0] = e0_c;
        ews_nxt   = ews_r - EWS_W'(eh_r[ERROR_TAPS-1]) + EWS_W'(e0_c);
        state_nxt = S_MULP;
      end
      S_MULP: begin
        dsum_nxt  = (MUL_B_W'(eh_r[0]) - MUL_B_W'(eh_r[3]))
                  + (MUL_B_W'(eh_r[1]) - MUL_B_W'(eh_r[2]));
        state_nxt = S_MULD;
      end
      S_MULD: begin
        sum_nxt   = SUM_W'(mul_p);
        state_nxt = S_MULI;
      end
      S_MULI: begin
        sum_nxt   = sum_r + SUM_W'(mul_p);
        state_nxt = S_ACC1;
      end
      S_ACC1: begin
        sum_nxt   = sum_r + SUM_W'(it_c);
        state_nxt = S_ACC2;
      end
      S_ACC2: begin
        mean_nxt = div_q;
        acc_nxt  = accsat_c;
        if (en_r) begin
          if (accsat_c > ACC_LIMIT) begin
            acc_nxt = ACC_LIMIT;
          end else if (accsat_c < -ACC_LIMIT) begin
            acc_nxt = -ACC_LIMIT;
          end
        end
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!(out_valid_r && out_stall)) begin
          out_nxt.duty          = en_r ? mag_c[DUTY_W+9:10] : '0;
          out_nxt.forward       = !acc_r[ACC_W-1];
          out_nxt.speed_now     = vel_r[VEL_W-1:8];
          out_nxt.speed_mean    = mean_r;
          out_nxt.distance_left = rem_r;
          out_nxt.stop_stage    = stage_r;
          out_nxt.motion_done   = done_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we && reg_idx_t'(cfg_index) == REG_CRUISE) begin
      cmd_nxt = cfg_data[SPD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gain_p_r    <= GAIN_P_RST;
      gain_i_r    <= GAIN_I_RST;
      gain_d_r    <= GAIN_D_RST;
      accel_r     <= ACCEL_RST;
      target_r    <= '0;
      window_r    <= '0;
      decel_r     <= '0;
      trav_r      <= '0;
      cmd_r       <= '0;
      ramp_r      <= '0;
      stage_r     <= STAGE_RUN;
      zt_r        <= '0;
      done_r      <= 1'b0;
      pos_r       <= '0;
      full_r      <= 1'b0;
      avg_r       <= '0;
      ews_r       <= '0;
      acc_r       <= '0;
      for (int i = 0; i < ERROR_TAPS; i++) begin
        eh_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      trav_r      <= trav_nxt;
      cmd_r       <= cmd_nxt;
      ramp_r      <= ramp_nxt;
      stage_r     <= stage_nxt;
      zt_r        <= zt_nxt;
      done_r      <= done_nxt;
      pos_r       <= pos_nxt;
      full_r      <= full_nxt;
      avg_r       <= avg_nxt;
      ews_r       <= ews_nxt;
      acc_r       <= acc_nxt;
      eh_r        <= eh_nxt;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_GAIN_P: gain_p_r <= cfg_data[GAIN_W-1:0];
          REG_GAIN_I: gain_i_r <= cfg_data[GAIN_W-1:0];
          REG_GAIN_D: gain_d_r <= cfg_data[GAIN_W-1:0];
          REG_ACCEL:  accel_r  <= cfg_data[ACCEL_W-1:0];
          REG_TARGET: target_r <= cfg_data[DIST_W-1:0];
          REG_WINDOW: window_r <= cfg_data[WIN_W-1:0];
          REG_CRUISE: begin
            // only loads the commanded velocity
          end
          REG_DECEL:  decel_r  <= cfg_data[SPD_W-1:0];
          default: begin
          end
        endcase
      end
    end
    cnt_r   <= cnt_nxt;
    en_r    <= en_nxt;
    delta_r <= delta_nxt;
    vel_r   <= vel_nxt;
    rem_r   <= rem_nxt;
    dsum_r  <= dsum_nxt;
    sum_r   <= sum_nxt;
    mean_r  <= mean_nxt;
    out_r   <= out_nxt;
  end

  // stop stage only returns to running through reset
  a_stage_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r != STAGE_RUN) |=> (stage_r != STAGE_RUN))
    else $error("stop stage returned to running");

  a_acc_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC2 && en_r) |=> (acc_r <= ACC_LIMIT && acc_r >= -ACC_LIMIT))
    else $error("enabled accumulator outside drive limit");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result beat changed");

  a_zero_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    zt_r <= ZT_W'(ZERO_TICKS_MAX))
    else $error("zero tick count overran");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT && state_nxt == S_IDLE) |=> out_valid_r)
    else $error("finished tick without a result");

endmodule
